/* hdl/lhtid_pkg.sv */
package lhtid_pkg;

   localparam int CAPACITY = 32;

   localparam int VAL_W = 32;
   localparam int POS_W = 6;
   localparam int CMD_W = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

   localparam int DATA_BITS = VAL_W + POS_W;
   localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

   typedef logic signed [VAL_W-1:0] elem_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [POS_W-1:0]        pos_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_DELETE     = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      count_type   count;
      pos_type     pos;
      elem_type    value;
   } cell_ctrl_type;

endpackage

/* hdl/list_head_tail_insert_index_delete_unit.sv */
// channel  dir  ports              tdata (low bit up)              tuser / tlast
// req      in   req_t*             item_value[31:0], position[37:32]  tuser: command
// rsp      out  rsp_t*             element_value[31:0],            tuser[0] list_empty,
//                                  element_position[37:32]         tuser[1] insert_dropped,
//                                                                  tlast: last_of_run
//
// Each item yields N results, N = list length after the command (1 when empty),
// at most CAPACITY. The row of cells applies the command in the accept cycle,
// then rotates one place per emitted result.
// reset (synchronous) empties the list; cell contents are not cleared.
// rsp_tready low stalls the rotation; the next item is taken once the run is queued.
module list_head_tail_insert_index_delete_unit
   import lhtid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // item_value, position, zero pad
   input  logic [CMD_W-1:0]  req_tuser,   // command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // element_value, element_position, zero pad
   output logic [1:0]        rsp_tuser,   // list_empty, insert_dropped
   output logic              rsp_tlast
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type     state_ff;
   count_type     count_ff;
   count_type     count_in;
   count_type     emit_idx_ff;
   logic          dropped_ff;
   logic          dropped_in;
   logic          rsp_valid_ff;
   elem_type      rsp_value_ff;
   pos_type       rsp_pos_ff;
   logic          rsp_last_ff;
   logic          rsp_empty_ff;
   logic          rsp_dropped_ff;

   cell_ctrl_type ctrl;
   elem_type      cell_value [CAPACITY];
   elem_type      req_value;
   pos_type       req_pos;
   logic          req_fire;
   logic          load;
   logic          list_empty;
   logic          run_last;
   logic [CMP_W-1:0] cnt_x;

   assign req_value  = elem_type'(req_tdata[VAL_W-1:0]);
   assign req_pos    = req_tdata[VAL_W +: POS_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign list_empty = (count_ff == '0);
   assign run_last   = list_empty ||
                       ((CMP_W'(emit_idx_ff) + CMP_W'(1)) == CMP_W'(count_ff));
   assign cnt_x      = CMP_W'(count_ff);

   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.count = count_ff;
      ctrl.pos   = req_pos;
      ctrl.value = req_value;
      count_in   = count_ff;
      dropped_in = 1'b0;
      if (req_fire) begin
         unique case (req_tuser)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (cnt_x >= CMP_W'(CAPACITY)) begin
                  dropped_in = 1'b1;
               end else begin
                  ctrl.op  = (req_tuser == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                           : CELL_PUSH_BACK;
                  count_in = count_ff + count_type'(1);
               end
            end
            CMD_DELETE: begin
               if (CMP_W'(req_pos) < cnt_x) begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - count_type'(1);
               end
            end
            default: ;
         endcase
      end else if (load && !list_empty) begin
         ctrl.op = CELL_ROTATE;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      elem_type left_v;
      elem_type right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      lhtid_cell u_cell (
         .clock       (clock),
         .idx         (IDX_W'(g)),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_fire) begin
                  count_ff    <= count_in;
                  dropped_ff  <= dropped_in;
                  emit_idx_ff <= '0;
                  state_ff    <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_value_ff   <= list_empty ? elem_type'(0) : cell_value[0];
                  rsp_pos_ff     <= POS_W'(emit_idx_ff);
                  rsp_last_ff    <= run_last;
                  rsp_empty_ff   <= list_empty;
                  rsp_dropped_ff <= dropped_ff;
                  emit_idx_ff    <= emit_idx_ff + count_type'(1);
                  if (run_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_pos_ff, rsp_value_ff});
   assign rsp_tuser  = {rsp_dropped_ff, rsp_empty_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/lhtid_cell.sv */
module lhtid_cell
   import lhtid_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] idx,
   input  cell_ctrl_type    ctrl,
   input  elem_type         left_value,
   input  elem_type         right_value,
   input  elem_type         head_value,
   output elem_type         value
);

   elem_type value_ff;
   elem_type value_in;

   logic [CMP_W-1:0] idx_x;
   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] pos_x;

   assign idx_x = CMP_W'(idx);
   assign cnt_x = CMP_W'(ctrl.count);
   assign pos_x = CMP_W'(ctrl.pos);

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         CELL_PUSH_FRONT: value_in = (idx_x == '0) ? ctrl.value : left_value;
         CELL_PUSH_BACK:  value_in = (idx_x == cnt_x) ? ctrl.value : value_ff;
         CELL_REMOVE:     value_in = (idx_x >= pos_x) ? right_value : value_ff;
         CELL_ROTATE: begin
            // tail slot catches the head so the list closes up after a full pass
            value_in = ((idx_x + CMP_W'(1)) == cnt_x) ? head_value : right_value;
         end
         default:         value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/lhtid_checker.sv */
module lhtid_checker
   import lhtid_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser,
   input logic              rsp_tlast
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=>
            rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp item changed under stall");

   property p_empty_form;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0);
   endproperty
   a_empty_form: assert property (p_empty_form) else $error("bad empty-list item");

   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready |=> !req_tready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("req taken during a run");

   property p_run_continues;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid;
   endproperty
   a_run_continues: assert property (p_run_continues) else $error("run broken off");

endmodule

bind list_head_tail_insert_index_delete_unit lhtid_checker u_lhtid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* verif/lhtid_listing_checker.sv */
module lhtid_listing_checker
   import lhtid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]  req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic [1:0]        rsp_tuser,
   input  logic              rsp_tlast,
   output int                fail_count,
   output int                pending,
   output int                list_len
);

   typedef struct packed {
      elem_type value;
      pos_type  pos;
      logic     last;
      logic     empty;
      logic     dropped;
   } listing_item_type;

   elem_type         shadow_list_q[$];
   listing_item_type listing_due_q[$];
   int               fails = 0;
   int               due_count = 0;
   int               shadow_len = 0;

   assign fail_count = fails;
   assign pending    = due_count;
   assign list_len   = shadow_len;

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input elem_type value,
                                input pos_type pos);
      logic             dropped;
      listing_item_type entry;
      dropped = 1'b0;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (shadow_list_q.size() >= CAPACITY)
               dropped = 1'b1;
            else if (cmd == CMD_PUSH_FRONT)
               shadow_list_q.push_front(value);
            else
               shadow_list_q.push_back(value);
         end
         CMD_DELETE: begin
            if (int'(pos) < shadow_list_q.size())
               shadow_list_q.delete(int'(pos));
         end
         default: ;
      endcase
      if (shadow_list_q.size() == 0) begin
         entry = '{value: '0, pos: '0, last: 1'b1, empty: 1'b1, dropped: dropped};
         listing_due_q.push_back(entry);
      end else begin
         for (int k = 0; k < shadow_list_q.size(); k++) begin
            entry.value   = shadow_list_q[k];
            entry.pos     = pos_type'(k);
            entry.last    = (k == shadow_list_q.size() - 1);
            entry.empty   = 1'b0;
            entry.dropped = dropped;
            listing_due_q.push_back(entry);
         end
      end
   endtask

   always @(posedge clock) begin
      listing_item_type got;
      listing_item_type want;
      if (reset) begin
         shadow_list_q.delete();
         listing_due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value   = elem_type'(rsp_tdata[VAL_W-1:0]);
            got.pos     = rsp_tdata[VAL_W +: POS_W];
            got.last    = rsp_tlast;
            got.empty   = rsp_tuser[0];
            got.dropped = rsp_tuser[1];
            if (listing_due_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected item: value %0d pos %0d last %b empty %b dropped %b",
                        $time, got.value, got.pos, got.last, got.empty, got.dropped);
            end else begin
               want = listing_due_q.pop_front();
               if (got !== want) begin
                  fails++;
                  $display("%0t: mismatch: expected value %0d pos %0d last %b empty %b dropped %b",
                           $time, want.value, want.pos, want.last, want.empty, want.dropped);
                  $display("%0t:           got value %0d pos %0d last %b empty %b dropped %b",
                           $time, got.value, got.pos, got.last, got.empty, got.dropped);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_command(req_tuser, elem_type'(req_tdata[VAL_W-1:0]),
                          req_tdata[VAL_W +: POS_W]);
      end
      due_count  = listing_due_q.size();
      shadow_len = shadow_list_q.size();
   end

endmodule

/* verif/list_head_tail_insert_index_delete_unit_tb.sv */
module list_head_tail_insert_index_delete_unit_tb;
   import lhtid_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int RANDOM_PER_PHASE  = 70;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]  req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;

   int   fail_count;
   int   pending;
   int   list_len;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   items_offered = 0;
   int   quiet_cycles = 0;
   logic stall_armed = 1'b0;

   always #5 clock = ~clock;

   list_head_tail_insert_index_delete_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lhtid_listing_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending),
      .list_len   (list_len)
   );

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic offer_item(input logic [CMD_W-1:0] cmd, input elem_type value,
                             input pos_type pos);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= DATA_W'({pos, value});
      do @(posedge clock); while (!req_tready);
      items_offered++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   function automatic elem_type pick_value();
      case ($urandom_range(7, 0))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic pos_type pick_victim();
      case ($urandom_range(2, 0))
         0: return '0;
         1: return pos_type'(list_len - 1);
         default: return pos_type'($urandom_range(list_len - 1, 0));
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_insert();
      return $urandom_range(1, 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
   endfunction

   task automatic fill_list();
      while (list_len < CAPACITY)
         offer_item(pick_insert(), pick_value(), pos_type'($urandom_range(63, 0)));
      repeat ($urandom_range(3, 1))
         offer_item(pick_insert(), pick_value(), pos_type'($urandom_range(63, 0)));
   endtask

   task automatic empty_list();
      while (list_len > 0)
         offer_item(CMD_DELETE, pick_value(), pick_victim());
      repeat ($urandom_range(2, 1))
         offer_item(CMD_DELETE, pick_value(), pos_type'($urandom_range(63, 0)));
   endtask

   task automatic mixed_commands();
      int pick;
      repeat ($urandom_range(12, 4)) begin
         pick = $urandom_range(9, 0);
         if (pick < 3)
            offer_item(CMD_PUSH_FRONT, pick_value(), pos_type'($urandom_range(63, 0)));
         else if (pick < 6)
            offer_item(CMD_PUSH_BACK, pick_value(), pos_type'($urandom_range(63, 0)));
         else if (pick < 8 && list_len > 0)
            offer_item(CMD_DELETE, pick_value(), pick_victim());
         else if (pick < 9)
            offer_item(CMD_DELETE, pick_value(), pos_type'($urandom_range(63, 0)));
         else
            offer_item(CMD_UNUSED, pick_value(), pos_type'($urandom_range(63, 0)));
      end
   endtask

   task automatic random_commands(input int count);
      int goal;
      goal = items_offered + count;
      while (items_offered < goal) begin
         case ($urandom_range(3, 0))
            0: fill_list();
            1: empty_list();
            default: mixed_commands();
         endcase
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_armed) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL_CYCLES - 1) @(negedge clock);
            stall_armed = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 87;
      offer_item(CMD_DELETE, '0, 6'd0);
      offer_item(CMD_DELETE, '0, 6'd63);
      offer_item(CMD_UNUSED, 32'h1234_5678, 6'd21);
      offer_item(CMD_PUSH_FRONT, 32'h8000_0000, 6'd0);
      offer_item(CMD_PUSH_BACK, 32'h7fff_ffff, 6'd63);
      offer_item(CMD_PUSH_FRONT, '1, 6'd0);
      offer_item(CMD_PUSH_BACK, '0, 6'd0);
      offer_item(CMD_PUSH_FRONT, 32'h5555_5555, 6'd21);
      offer_item(CMD_DELETE, '0, 6'd63);
      offer_item(CMD_DELETE, '0, 6'd5);
      offer_item(CMD_DELETE, '0, 6'd4);
      offer_item(CMD_DELETE, '0, 6'd0);
      offer_item(CMD_DELETE, '1, 6'd1);
      offer_item(CMD_UNUSED, 32'haaaa_aaaa, 6'd42);
      offer_item(CMD_PUSH_BACK, 32'haaaa_aaaa, 6'd42);
      offer_item(CMD_DELETE, '0, 6'd0);
      offer_item(CMD_DELETE, '0, 6'd0);
      offer_item(CMD_DELETE, '0, 6'd0);
      wait_drained();

      fill_list();
      random_commands(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 87;
      recv_idle_pct = 18;
      random_commands(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_armed   = 1'b1;
      fill_list();
      random_commands(RANDOM_PER_PHASE);

      wait_drained();
      repeat (2 * (CAPACITY + 1)) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hdl/lhtid_pkg.sv
hdl/lhtid_cell.sv
hdl/list_head_tail_insert_index_delete_unit.sv
hdl/lhtid_checker.sv
verif/lhtid_listing_checker.sv
verif/list_head_tail_insert_index_delete_unit_tb.sv
